// ===== rtl/clt_pkg.sv =====
// Shared types, constants and address decode for the core-local timer block.
`timescale 1ns / 1ps

package clt_pkg;

    localparam int MAX_HARTS = 8;
    localparam int HART_W = (MAX_HARTS > 1) ? $clog2(MAX_HARTS) : 1;
    localparam int CNT_W = $clog2(MAX_HARTS + 1);
    localparam int MASK_N = (MAX_HARTS < 8) ? MAX_HARTS : 8;

    localparam int OFF_W = 20;
    localparam int EOFF_W = OFF_W + 1;
    localparam int SOFT_IDX_W = 12;
    localparam int WORD_SHIFT = 32;

    localparam logic [EOFF_W-1:0] CMP_BASE = 21'h04000;
    localparam logic [EOFF_W-1:0] CMP_END = CMP_BASE + EOFF_W'(8 * MAX_HARTS);
    localparam logic [EOFF_W-1:0] TIME_MAIN = 21'h0bff8;
    localparam logic [EOFF_W-1:0] TIME_ALIAS = 21'h07ff8;
    localparam logic [EOFF_W-1:0] SOFT_ALIAS = 21'h80000;
    localparam logic [EOFF_W-1:0] SOFT_ALIAS_END = 21'h84000;
    localparam logic [EOFF_W-1:0] HALF_STEP = 21'd4;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        WK_NONE,
        WK_SOFT,
        WK_CMP,
        WK_TIME
    } word_kind_t;

    typedef struct packed {
        word_kind_t              kind;
        logic                    high;
        logic                    time_wr;
        logic [SOFT_IDX_W-1:0]   soft_hart;
        logic [HART_W-1:0]       cmp_hart;
    } word_dec_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [19:0] byte_offset;
        logic        wide_access;
        logic [63:0] write_data;
    } item_t;

    typedef struct packed {
        logic [63:0] read_data;
        logic [7:0]  soft_pending;
        logic [7:0]  timer_pending;
    } res_t;

    function automatic word_dec_t decode_word(input logic [EOFF_W-1:0] off);
        word_dec_t d;
        logic [EOFF_W-1:0] rel;
        rel = off - CMP_BASE;
        d.kind = WK_NONE;
        d.high = 1'b0;
        d.time_wr = 1'b0;
        d.soft_hart = off[13:2];
        d.cmp_hart = HART_W'(rel >> 3);
        if (off < CMP_BASE || (off >= SOFT_ALIAS && off < SOFT_ALIAS_END))
        begin
            d.kind = WK_SOFT;
        end
        else if (off < CMP_END)
        begin
            d.kind = WK_CMP;
            d.high = (off[2:0] == 3'd4);
        end
        else if (off == TIME_MAIN || off == TIME_ALIAS)
        begin
            d.kind = WK_TIME;
            d.time_wr = (off == TIME_MAIN);
        end
        else if (off == TIME_MAIN + HALF_STEP || off == TIME_ALIAS + HALF_STEP)
        begin
            d.kind = WK_TIME;
            d.high = 1'b1;
            d.time_wr = (off == TIME_MAIN + HALF_STEP);
        end
        return d;
    endfunction

endpackage

// ===== rtl/core_local_timer_interruptor.sv =====
// Top level of the core-local timer and software-interrupt block.
//
// The slave stream carries one item per handshake: a 4- or 8-byte register
// read, a register write, or one tick of the 64-bit time counter. The kind
// of item travels in s_axis_tuser. Every accepted item produces exactly one
// result on the master stream with the read data and the per-hart software-
// and timer-pending masks as they stand after the item.
// The block takes one item per cycle while m_axis_tready is not held low. An
// item is registered in the input register on acceptance, then decoded,
// merged into the state and turned into a result held in the output register.
// A result waits in the output register while the receiver holds
// m_axis_tready low; one further item may wait in the input register, after
// which s_axis_tready drops until the result is taken.
// The harts_present register is written through cfg_we and cfg_wdata; the user
// must do so while no item is in flight, as the block itself does not enforce it.
// Reset sets the time counter to one, every compare value to all ones, every
// software-pending bit to zero, harts_present to one, and empties both stages.
`timescale 1ns / 1ps

module core_local_timer_interruptor
    import clt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: byte_offset[19:0], wide_access, write_data[63:0], zero fill.
    input  logic [87:0] s_axis_tdata,
    // Fields from bit 0: cmd[1:0].
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0: read_data[63:0], soft_pending[7:0], timer_pending[7:0].
    output logic [79:0] m_axis_tdata
);

    logic  in_valid_reg;
    logic  in_valid_next;
    item_t in_item_reg;
    logic  out_valid_reg;
    logic  out_valid_next;
    res_t  out_res_reg;
    res_t  res;
    item_t in_item;
    logic  accept;
    logic  advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_item.cmd = s_axis_tuser;
        in_item.byte_offset = s_axis_tdata[19:0];
        in_item.wide_access = s_axis_tdata[20];
        in_item.write_data = s_axis_tdata[84:21];

        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    clt_state u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item_go   (advance),
        .item      (in_item_reg),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {out_res_reg.timer_pending, out_res_reg.soft_pending,
                           out_res_reg.read_data};

endmodule

// ===== rtl/clt_state.sv =====
// Timer state, compare and software-pending registers with access decode and merge.
`timescale 1ns / 1ps

module clt_state
    import clt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata,
    input  logic       item_go,
    input  item_t      item,
    output res_t       res
);

    logic [3:0]            harts_reg;
    logic [63:0]           time_reg;
    logic [63:0]           time_next;
    logic [63:0]           cmp_reg [MAX_HARTS];
    logic [63:0]           cmp_next [MAX_HARTS];
    logic [MAX_HARTS-1:0]  soft_reg;
    logic [MAX_HARTS-1:0]  soft_next;

    logic [EOFF_W-1:0]     off_a;
    logic [EOFF_W-1:0]     off_b;
    word_dec_t             dec_a;
    word_dec_t             dec_b;
    logic                  is_read;
    logic                  is_write;
    logic                  is_tick;
    logic                  time_full;
    logic                  cmp_full;
    logic                  use_b;
    logic [CNT_W-1:0]      present_n;
    logic                  present_a;
    logic                  present_b;
    logic [HART_W-1:0]     cmp_sel;
    logic [63:0]           cmp_rd;
    logic [31:0]           rd_a;
    logic [31:0]           rd_b;

    always_comb
    begin
        off_a = {1'b0, item.byte_offset};
        off_b = off_a + HALF_STEP;
        dec_a = decode_word(off_a);
        dec_b = decode_word(off_b);
        is_read = (item.cmd == CMD_READ);
        is_write = (item.cmd == CMD_WRITE);
        is_tick = (item.cmd == CMD_TICK);
        time_full = item.wide_access && (off_a == TIME_MAIN || off_a == TIME_ALIAS);
        cmp_full = item.wide_access && !time_full && (dec_a.kind == WK_CMP);
        use_b = item.wide_access && !time_full && !cmp_full;

        if (harts_reg == 4'd0)
        begin
            present_n = CNT_W'(1);
        end
        else if (int'(harts_reg) > MAX_HARTS)
        begin
            present_n = CNT_W'(MAX_HARTS);
        end
        else
        begin
            present_n = CNT_W'(harts_reg);
        end
        present_a = dec_a.soft_hart < SOFT_IDX_W'(present_n);
        present_b = dec_b.soft_hart < SOFT_IDX_W'(present_n);

        cmp_sel = (dec_a.kind == WK_CMP) ? dec_a.cmp_hart : dec_b.cmp_hart;
        cmp_rd = cmp_reg[cmp_sel];

        case (dec_a.kind)
            WK_SOFT: rd_a = {31'd0, soft_reg[dec_a.soft_hart[HART_W-1:0]] & present_a};
            WK_CMP:  rd_a = dec_a.high ? cmp_rd[63:32] : cmp_rd[31:0];
            WK_TIME: rd_a = dec_a.high ? time_reg[63:32] : time_reg[31:0];
            default: rd_a = 32'd0;
        endcase
        case (dec_b.kind)
            WK_SOFT: rd_b = {31'd0, soft_reg[dec_b.soft_hart[HART_W-1:0]] & present_b};
            WK_CMP:  rd_b = dec_b.high ? cmp_rd[63:32] : cmp_rd[31:0];
            WK_TIME: rd_b = dec_b.high ? time_reg[63:32] : time_reg[31:0];
            default: rd_b = 32'd0;
        endcase

        if (!is_read)
        begin
            res.read_data = 64'd0;
        end
        else if (time_full)
        begin
            res.read_data = time_reg;
        end
        else if (cmp_full)
        begin
            res.read_data = cmp_rd;
        end
        else if (use_b)
        begin
            res.read_data = {rd_b, rd_a};
        end
        else
        begin
            res.read_data = {32'd0, rd_a};
        end

        time_next = time_reg;
        if (is_tick)
        begin
            time_next = time_reg + 64'd1;
        end
        else if (is_write)
        begin
            if (time_full)
            begin
                time_next = item.write_data;
            end
            else
            begin
                if (dec_a.kind == WK_TIME && dec_a.time_wr)
                begin
                    if (dec_a.high)
                    begin
                        time_next[63:32] = item.write_data[31:0];
                    end
                    else
                    begin
                        time_next[31:0] = item.write_data[31:0];
                    end
                end
                if (use_b && dec_b.kind == WK_TIME && dec_b.time_wr)
                begin
                    if (dec_b.high)
                    begin
                        time_next[63:32] = item.write_data[63:32];
                    end
                    else
                    begin
                        time_next[31:0] = item.write_data[63:32];
                    end
                end
            end
        end

        for (int h = 0; h < MAX_HARTS; h++)
        begin
            cmp_next[h] = cmp_reg[h];
            soft_next[h] = soft_reg[h];
            if (is_write)
            begin
                if (cmp_full)
                begin
                    if (dec_a.cmp_hart == HART_W'(h))
                    begin
                        cmp_next[h] = item.write_data;
                    end
                end
                else
                begin
                    if (dec_a.kind == WK_CMP && dec_a.cmp_hart == HART_W'(h))
                    begin
                        if (dec_a.high)
                        begin
                            cmp_next[h][63:32] = item.write_data[31:0];
                        end
                        else
                        begin
                            cmp_next[h][31:0] = item.write_data[31:0];
                        end
                    end
                    if (use_b && dec_b.kind == WK_CMP && dec_b.cmp_hart == HART_W'(h))
                    begin
                        if (dec_b.high)
                        begin
                            cmp_next[h][63:32] = item.write_data[63:32];
                        end
                        else
                        begin
                            cmp_next[h][31:0] = item.write_data[63:32];
                        end
                    end
                end
                if (dec_a.kind == WK_SOFT && present_a
                    && dec_a.soft_hart == SOFT_IDX_W'(h))
                begin
                    soft_next[h] = item.write_data[0];
                end
                if (use_b && dec_b.kind == WK_SOFT && present_b
                    && dec_b.soft_hart == SOFT_IDX_W'(h))
                begin
                    soft_next[h] = item.write_data[32];
                end
            end
        end

        res.soft_pending = 8'd0;
        res.timer_pending = 8'd0;
        for (int h = 0; h < MASK_N; h++)
        begin
            res.soft_pending[h] = soft_next[h] && (CNT_W'(h) < present_n);
            res.timer_pending[h] = (time_next >= cmp_next[h]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            harts_reg <= 4'd1;
        end
        else if (cfg_we)
        begin
            harts_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= 64'd1;
            soft_reg <= '0;
            for (int h = 0; h < MAX_HARTS; h++)
            begin
                cmp_reg[h] <= '1;
            end
        end
        else if (item_go)
        begin
            time_reg <= time_next;
            soft_reg <= soft_next;
            for (int h = 0; h < MAX_HARTS; h++)
            begin
                cmp_reg[h] <= cmp_next[h];
            end
        end
    end

endmodule

// ===== rtl/clt_checker.sv =====
// Port-level checker for the core-local timer block and its bind.
`timescale 1ns / 1ps

module clt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata
);

    logic s_acc;

    assign s_acc = s_axis_tvalid && s_axis_tready;

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

    // The input side only stalls when a result is held back by the receiver.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

    // A result that appears on an empty output came from an item that passed through the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_acc, 2))
    else $error("result appeared without a matching item");

endmodule

bind core_local_timer_interruptor clt_checker u_clt_checker (.*);
